// ===== hdl/dbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dbr_pkg;

  // build defaults
  localparam int MAX_ARMS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;

  // field widths
  localparam int CMD_W     = 2;
  localparam int RND_W     = 16;
  localparam int ARM_OUT_W = 3;
  localparam int ARMCNT_W  = 4;
  localparam int ALPHA_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // fixed-point widths
  localparam int STEP_W = 32;
  localparam int LG_W   = 21;   // log2 t in Q16
  localparam int LN_W   = 21;   // ln t in Q16
  localparam int AQ_W   = 37;   // alpha * ln t
  localparam int MEAN_W = 17;
  localparam int SQ_VW  = 42;
  localparam int ROOT_W = 21;
  localparam int SQ_RW  = 23;
  localparam int UCB_W  = 22;

  localparam logic [31:0]      LN2_Q32  = 32'd2977044472;
  localparam logic [UCB_W-1:0] HALF_Q16 = UCB_W'(32768);
  localparam logic [UCB_W-1:0] TWO_Q16  = UCB_W'(131072);

  localparam logic [ARMCNT_W-1:0] ARM_COUNT_RST = ARMCNT_W'(8);
  localparam logic [ALPHA_W-1:0]  ALPHA_RST     = ALPHA_W'(2089);

  typedef enum logic [CMD_W-1:0] {
    CMD_SELECT  = 2'd0,
    CMD_OUTCOME = 2'd1,
    CMD_WINNER  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_COUNT = 1'b0,
    CFG_ALPHA     = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

// ===== hdl/dbr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface dbr_in_if import dbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [RND_W-1:0] random_value;
  logic             first_won;

  modport source (output valid, output cmd, output random_value, output first_won,
                  input ready);
  modport sink (input valid, input cmd, input random_value, input first_won,
                output ready);
endinterface

// result channel
interface dbr_out_if import dbr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ARM_OUT_W-1:0] first_arm;
  logic [ARM_OUT_W-1:0] second_arm;
  logic                 had_candidates;
  logic [ARM_OUT_W-1:0] best_arm;

  modport source (output valid, output first_arm, output second_arm,
                  output had_candidates, output best_arm, input ready);
  modport sink (input valid, input first_arm, input second_arm,
                input had_candidates, input best_arm, output ready);
endinterface

`default_nettype wire

// ===== hdl/dbr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/dueling_bandit_rucb_selector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dueling-bandit pair selector (relative upper confidence bound).
// in_chan carries one command per transaction: select a pair, report the
// outcome of the pending duel, or query the current winner. out_chan returns
// exactly one result transaction per command. cfg_* writes the arm count
// (index 0) and alpha (index 1); the user must write them only while the
// block is idle, as the block itself does not enforce this.
// in_chan.ready is high only while the sequencer is idle; one command is
// worked on at a time. A select works out ln t, then each off-diagonal
// bound through the bit-serial divider and square-root unit, which all
// bounds share, over n*n row bounds plus n column bounds. A winner query
// scans every arm pair.
// Results sit in an output register: a stalled receiver holds the result,
// and the next command is still accepted and worked on, finishing only when
// the register frees up.
// Reset (synchronous, rst_n low) clears the win counts through per-entry
// valid bits, the step count and the pending pair, and loads the default
// arm count of 8 and alpha of 2089 (Q4.12). No clearing pass is needed.
module dueling_bandit_rucb_selector_unit import dbr_pkg::*; #(
  parameter int MAX_ARMS   = MAX_ARMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dbr_in_if.sink                    in_chan,
  dbr_out_if.source                 out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_ARMS);
  localparam int CNTW  = $clog2(MAX_ARMS + 1);
  localparam int DEPTH = MAX_ARMS * MAX_ARMS;
  localparam int AD    = $clog2(DEPTH);
  localparam int CW    = COUNT_BITS;
  localparam int DW    = CW + 1;
  localparam int RW    = CW + 2;
  localparam int NW    = (CW + 16 > AQ_W) ? CW + 16 : AQ_W;
  localparam int NCW   = $clog2(NW);

  typedef enum logic [4:0] {
    S_IDLE, S_LNORM, S_LSQ, S_LUPD, S_LNMUL, S_LNGET, S_AQMUL, S_AQGET,
    S_PAIR, S_RD1, S_RD2, S_RD3, S_DIVM, S_DIVQ, S_SQRT, S_UCB,
    S_PICK, S_WALK, S_WADV, S_ORD, S_OWR, S_DONE
  } state_t;

  state_t state_r;
  cmd_t   op_r;

  logic [ARMCNT_W-1:0] arm_count_r;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [STEP_W-1:0]   step_r;
  logic [AW-1:0]       pend_first_r, pend_second_r;
  logic [DEPTH-1:0]    wvalid_r;
  logic                rvalid_r;
  logic [RND_W-1:0]    rnd_r;

  logic [31:0]         x_r;
  logic [4:0]          k_r;
  logic [3:0]          b_r;
  logic [LG_W-1:0]     lg_r;
  logic [LN_W-1:0]     ln_r;
  logic [AQ_W-1:0]     aln_r;
  logic [63:0]         prod_r;

  logic [AW-1:0]       i_r, j_r, c_r, d_r, best_r;
  logic                pass_r;
  logic                ok_r;
  logic [MAX_ARMS-1:0] cand_r;
  logic [CNTW-1:0]     nc_r, k_pick_r, cnt_r, bestc_r;
  logic [CW-1:0]       wa_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [UCB_W-1:0]    ucb_r, bestu_r;

  logic [NW-1:0]       dv_num_r;
  logic [RW-1:0]       dv_rem_r;
  logic [DW-1:0]       dv_den_r;
  logic [NCW-1:0]      dv_cnt_r;

  logic [SQ_VW-1:0]    sq_v_r;
  logic [SQ_RW-1:0]    sq_rem_r;
  logic [ROOT_W-1:0]   sq_root_r;
  logic [4:0]          sq_cnt_r;

  logic [ARM_OUT_W-1:0] res_first_r, res_second_r, res_best_r;
  logic                 res_had_r;
  logic                 out_valid_r;
  logic [ARM_OUT_W-1:0] out_first_r, out_second_r, out_best_r;
  logic                 out_had_r;

  // arm index to output field width
  function automatic logic [ARM_OUT_W-1:0] to_out(input logic [AW-1:0] a);
    logic [AW+ARM_OUT_W-1:0] e;
    e = {{ARM_OUT_W{1'b0}}, a};
    return e[ARM_OUT_W-1:0];
  endfunction

  function automatic logic [AD-1:0] pair_addr(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
    return AD'(AD'(a) * AD'(MAX_ARMS) + AD'(b));
  endfunction

  // arms in use, clamped to the built range
  logic [CNTW-1:0] n_use;
  logic [AW-1:0]   n_last;
  always_comb begin
    if ({1'b0, arm_count_r} < 5'd2) begin
      n_use = CNTW'(2);
    end else if (32'(arm_count_r) > 32'(MAX_ARMS)) begin
      n_use = CNTW'(MAX_ARMS);
    end else begin
      n_use = CNTW'(arm_count_r);
    end
    n_last = AW'(n_use - CNTW'(1));
  end

  // win-count memory
  logic [AD-1:0] raddr, waddr;
  logic [CW-1:0] rdata, wdata, rd_w;
  logic          we;

  assign raddr = (state_r == S_RD2) ? pair_addr(j_r, i_r) : pair_addr(i_r, j_r);
  assign waddr = pair_addr(i_r, j_r);
  assign rd_w  = rvalid_r ? rdata : '0;
  assign we    = (state_r == S_OWR);
  assign wdata = (rd_w == {CW{1'b1}}) ? rd_w : rd_w + CW'(1);

  dbr_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_wins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    unique case (state_r)
      S_LSQ: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_LNMUL: begin
        mul_a = 32'(lg_r);
        mul_b = LN2_Q32;
      end
      S_AQMUL: begin
        mul_a = 32'(alpha_r);
        mul_b = 32'(ln_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // log squaring update
  logic [32:0] xs;
  assign xs = prod_r[63:31];

  // restoring divider step
  logic [RW-1:0] dv_rem_sh, dv_rem_n;
  logic          dv_ge;
  logic [NW-1:0] dv_num_n;
  always_comb begin
    dv_rem_sh = {dv_rem_r[RW-2:0], dv_num_r[NW-1]};
    dv_ge     = dv_rem_sh >= {1'b0, dv_den_r};
    dv_rem_n  = dv_ge ? dv_rem_sh - {1'b0, dv_den_r} : dv_rem_sh;
    dv_num_n  = {dv_num_r[NW-2:0], dv_ge};
  end

  // square-root digit step
  logic [SQ_RW-1:0]  sq_rem_sh, sq_trial, sq_rem_n;
  logic              sq_ge;
  logic [ROOT_W-1:0] sq_root_n;
  always_comb begin
    sq_rem_sh = {sq_rem_r[SQ_RW-3:0], sq_v_r[SQ_VW-1 -: 2]};
    sq_trial  = {sq_root_r, 2'b01};
    sq_ge     = sq_rem_sh >= sq_trial;
    sq_rem_n  = sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
    sq_root_n = {sq_root_r[ROOT_W-2:0], sq_ge};
  end

  // pair totals
  logic [DW-1:0] n_pair;
  logic          beat;
  assign n_pair = {1'b0, wa_r} + {1'b0, rd_w};
  assign beat   = (n_pair == '0) || ({wa_r, 1'b0} > n_pair);

  // row-pass bookkeeping
  logic          ok_n;
  logic [CNTW-1:0] nc_n;
  assign ok_n = ok_r && (ucb_r >= HALF_Q16);
  assign nc_n = nc_r + CNTW'(ok_n);

  logic              accept;
  logic [STEP_W-1:0] step_n;
  assign accept = in_chan.valid && in_chan.ready;
  assign step_n = (step_r == {STEP_W{1'b1}}) ? step_r : step_r + STEP_W'(1);

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.first_arm      = out_first_r;
  assign out_chan.second_arm     = out_second_r;
  assign out_chan.had_candidates = out_had_r;
  assign out_chan.best_arm       = out_best_r;

  // multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_count_r <= ARM_COUNT_RST;
      alpha_r     <= ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ARM_COUNT: arm_count_r <= cfg_wdata[ARMCNT_W-1:0];
        CFG_ALPHA:     alpha_r     <= cfg_wdata[ALPHA_W-1:0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    rvalid_r <= wvalid_r[raddr];
    if (!rst_n) begin
      state_r       <= S_IDLE;
      op_r          <= CMD_NONE;
      step_r        <= '0;
      pend_first_r  <= '0;
      pend_second_r <= '0;
      wvalid_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r         <= cmd_t'(in_chan.cmd);
            res_first_r  <= '0;
            res_second_r <= '0;
            res_had_r    <= 1'b0;
            res_best_r   <= '0;
            unique case (cmd_t'(in_chan.cmd))
              CMD_SELECT: begin
                step_r  <= step_n;
                x_r     <= step_n;
                k_r     <= 5'd31;
                rnd_r   <= in_chan.random_value;
                state_r <= S_LNORM;
              end
              CMD_OUTCOME: begin
                i_r     <= in_chan.first_won ? pend_first_r : pend_second_r;
                j_r     <= in_chan.first_won ? pend_second_r : pend_first_r;
                state_r <= S_ORD;
              end
              CMD_WINNER: begin
                i_r     <= '0;
                j_r     <= '0;
                cnt_r   <= '0;
                bestc_r <= '0;
                best_r  <= '0;
                state_r <= S_PAIR;
              end
              CMD_NONE: state_r <= S_DONE;
            endcase
          end
        end
        // integer part of log2 t
        S_LNORM: begin
          if (x_r[31]) begin
            lg_r    <= {k_r, 16'h0000};
            b_r     <= 4'd15;
            state_r <= S_LSQ;
          end else begin
            x_r <= {x_r[30:0], 1'b0};
            k_r <= k_r - 5'd1;
          end
        end
        S_LSQ: state_r <= S_LUPD;
        // fraction bits by repeated squaring
        S_LUPD: begin
          if (xs[32]) begin
            lg_r[{1'b0, b_r}] <= 1'b1;
            x_r <= xs[32:1];
          end else begin
            x_r <= xs[31:0];
          end
          if (b_r == 4'd0) begin
            state_r <= S_LNMUL;
          end else begin
            b_r     <= b_r - 4'd1;
            state_r <= S_LSQ;
          end
        end
        S_LNMUL: state_r <= S_LNGET;
        S_LNGET: begin
          ln_r    <= prod_r[32 +: LN_W];
          state_r <= S_AQMUL;
        end
        S_AQMUL: state_r <= S_AQGET;
        S_AQGET: begin
          aln_r   <= prod_r[AQ_W-1:0];
          i_r     <= '0;
          j_r     <= '0;
          pass_r  <= 1'b0;
          ok_r    <= 1'b1;
          cand_r  <= '0;
          nc_r    <= '0;
          state_r <= S_PAIR;
        end
        S_PAIR: begin
          if (i_r == j_r) begin
            if (op_r == CMD_WINNER) begin
              state_r <= S_WADV;
            end else begin
              ucb_r   <= HALF_Q16;
              state_r <= S_UCB;
            end
          end else begin
            state_r <= S_RD1;
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          wa_r    <= rd_w;
          state_r <= S_RD3;
        end
        S_RD3: begin
          if (op_r == CMD_WINNER) begin
            cnt_r   <= cnt_r + CNTW'(beat);
            state_r <= S_WADV;
          end else if (n_pair == '0) begin
            ucb_r   <= TWO_Q16;
            state_r <= S_UCB;
          end else begin
            dv_num_r <= NW'({wa_r, 16'h0000});
            dv_den_r <= n_pair;
            dv_rem_r <= '0;
            dv_cnt_r <= NCW'(NW - 1);
            state_r  <= S_DIVM;
          end
        end
        // mean term
        S_DIVM: begin
          if (dv_cnt_r == '0) begin
            mean_r   <= dv_num_n[MEAN_W-1:0];
            dv_num_r <= NW'(aln_r);
            dv_rem_r <= '0;
            dv_cnt_r <= NCW'(NW - 1);
            state_r  <= S_DIVQ;
          end else begin
            dv_rem_r <= dv_rem_n;
            dv_num_r <= dv_num_n;
            dv_cnt_r <= dv_cnt_r - NCW'(1);
          end
        end
        // exploration quotient
        S_DIVQ: begin
          dv_rem_r <= dv_rem_n;
          dv_num_r <= dv_num_n;
          dv_cnt_r <= dv_cnt_r - NCW'(1);
          if (dv_cnt_r == '0) begin
            sq_v_r    <= {1'b0, dv_num_n[AQ_W-1:0], 4'h0};
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= 5'(ROOT_W - 1);
            state_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rem_r  <= sq_rem_n;
          sq_root_r <= sq_root_n;
          sq_v_r    <= {sq_v_r[SQ_VW-3:0], 2'b00};
          sq_cnt_r  <= sq_cnt_r - 5'd1;
          if (sq_cnt_r == 5'd0) begin
            ucb_r   <= UCB_W'(mean_r) + UCB_W'(sq_root_n);
            state_r <= S_UCB;
          end
        end
        S_UCB: begin
          if (!pass_r) begin
            // row pass: candidate rows
            if (j_r == n_last) begin
              if (ok_n) begin
                cand_r[i_r] <= 1'b1;
              end
              nc_r <= nc_n;
              if (i_r == n_last) begin
                dv_num_r <= NW'(rnd_r);
                dv_den_r <= (nc_n != '0) ? DW'(nc_n) : DW'(n_use);
                dv_rem_r <= '0;
                dv_cnt_r <= NCW'(NW - 1);
                state_r  <= S_PICK;
              end else begin
                i_r     <= i_r + AW'(1);
                j_r     <= '0;
                ok_r    <= 1'b1;
                state_r <= S_PAIR;
              end
            end else begin
              j_r     <= j_r + AW'(1);
              ok_r    <= ok_n;
              state_r <= S_PAIR;
            end
          end else begin
            // column pass: first argmax
            if (i_r == '0 || ucb_r > bestu_r) begin
              bestu_r <= ucb_r;
              d_r     <= i_r;
            end
            if (i_r == n_last) begin
              pend_first_r  <= c_r;
              pend_second_r <= (i_r == '0 || ucb_r > bestu_r) ? i_r : d_r;
              res_first_r   <= to_out(c_r);
              res_second_r  <= to_out((i_r == '0 || ucb_r > bestu_r) ? i_r : d_r);
              res_had_r     <= (nc_r != '0);
              state_r       <= S_DONE;
            end else begin
              i_r     <= i_r + AW'(1);
              state_r <= S_PAIR;
            end
          end
        end
        // random value mod candidate count, or mod arm count if there are none
        S_PICK: begin
          dv_rem_r <= dv_rem_n;
          dv_num_r <= dv_num_n;
          dv_cnt_r <= dv_cnt_r - NCW'(1);
          if (dv_cnt_r == '0) begin
            if (nc_r != '0) begin
              k_pick_r <= dv_rem_n[CNTW-1:0];
              i_r      <= '0;
              state_r  <= S_WALK;
            end else begin
              c_r     <= dv_rem_n[AW-1:0];
              j_r     <= dv_rem_n[AW-1:0];
              i_r     <= '0;
              pass_r  <= 1'b1;
              state_r <= S_PAIR;
            end
          end
        end
        // find the chosen candidate row
        S_WALK: begin
          if (cand_r[i_r] && k_pick_r == '0) begin
            c_r     <= i_r;
            j_r     <= i_r;
            i_r     <= '0;
            pass_r  <= 1'b1;
            state_r <= S_PAIR;
          end else begin
            if (cand_r[i_r]) begin
              k_pick_r <= k_pick_r - CNTW'(1);
            end
            i_r <= i_r + AW'(1);
          end
        end
        // winner scan advance
        S_WADV: begin
          if (j_r == n_last) begin
            if (cnt_r > bestc_r) begin
              bestc_r <= cnt_r;
              best_r  <= i_r;
            end
            if (i_r == n_last) begin
              res_best_r <= to_out((cnt_r > bestc_r) ? i_r : best_r);
              state_r    <= S_DONE;
            end else begin
              i_r     <= i_r + AW'(1);
              j_r     <= '0;
              cnt_r   <= '0;
              state_r <= S_PAIR;
            end
          end else begin
            j_r     <= j_r + AW'(1);
            state_r <= S_PAIR;
          end
        end
        S_ORD: state_r <= S_OWR;
        // saturating win credit
        S_OWR: begin
          wvalid_r[waddr] <= 1'b1;
          state_r         <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_first_r  <= res_first_r;
            out_second_r <= res_second_r;
            out_had_r    <= res_had_r;
            out_best_r   <= res_best_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
